// ----- hdl/smct_pkg.sv -----
// Shared types, constants and AES helper functions for the secure-messaging MAC block.
package smct_pkg;

	typedef struct packed {
		logic       first_item;
		logic [7:0] command_code;
		logic [7:0] body_byte;
		logic       byte_present;
		logic       last_item;
	} smct_in_t;

	typedef struct packed {
		logic [63:0] mac_short;
		logic        too_long;
	} smct_out_t;

	typedef struct packed {
		logic [127:0] key;
		logic [31:0]  transaction_id;
		logic [15:0]  command_counter;
	} smct_cfg_t;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW         = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSACTION_ID  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_COUNTER = 8'd3;

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [7:0] CMAC_RB     = 8'h87;
	localparam logic [7:0] AES_POLY    = 8'h1b;
	localparam logic [7:0] RCON_FIRST  = 8'h01;
	localparam logic [3:0] AES_ROUNDS  = 4'd10;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
	endfunction

	// Byte 0 of a block sits in the top bits.
	function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
		return v[8*(15-i) +: 8];
	endfunction

	function automatic logic [127:0] set_byte(input logic [127:0] v, input logic [3:0] idx,
			input logic [7:0] b);
		logic [127:0] r;
		r = v;
		for (int i = 0; i < 16; i++) begin
			if (idx == 4'(i)) begin
				r[8*(15-i) +: 8] = b;
			end
		end
		return r;
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0]   t [0:15];
		logic [7:0]   a0, a1, a2, a3, x;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				t[j+4*c] = SBOX[get_byte(s, j + 4*((c+j) % 4))];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c];
				a1 = t[4*c+1];
				a2 = t[4*c+2];
				a3 = t[4*c+3];
				x = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
				t[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
				t[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
				t[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[8*(15-i) +: 8] = t[i];
		end
		return r;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] w, w0, w1, w2, w3;
		w = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
		w0 = rk[127:96] ^ w;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] gf_dbl(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CMAC_RB} : 128'd0);
	endfunction

endpackage

// ----- hdl/secure_message_cmac_truncated_top.sv -----
// Top level of the secure-messaging truncated AES-128 CMAC block.
//
//  channel | signals                          | direction | transfer when
//  in      | in_valid, in_stall, in_data      | into block | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data   | out of block | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block | cfg_valid && cfg_ready
//
// A plain body item passes through the sequencer's idle and body states; an item that opens a
// message first passes through the header state once per header byte. Every completed 16-byte
// block is chained through the round-per-cycle AES core, and the final item adds two AES passes
// (unless the message is too long) before its transfer.
// Reset empties the queue and clears the message state and the configuration registers to zero. A two-entry queue
// lets input transfers continue while the sequencer or the output register is held.
module secure_message_cmac_truncated_top #(
	parameter int MAX_MESSAGE_BYTES = 48,
	parameter int TI_BYTES          = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  smct_pkg::smct_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output smct_pkg::smct_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                         cfg_data
);
	import smct_pkg::*;

	smct_cfg_t cfg_q;
	logic      q_valid, q_pop;
	smct_in_t  q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_HIGH:        cfg_q.key[127:64]     <= cfg_data;
				CFG_KEY_LOW:         cfg_q.key[63:0]       <= cfg_data;
				CFG_TRANSACTION_ID:  cfg_q.transaction_id  <= cfg_data[31:0];
				CFG_COMMAND_COUNTER: cfg_q.command_counter <= cfg_data[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	smct_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data)
	);

	smct_back #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
		.TI_BYTES         (TI_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ----- hdl/smct_front.sv -----
// Input side: accepts items and holds them in a two-entry queue for the sequencer.
module smct_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smct_pkg::smct_in_t in_data,
	output logic               q_valid,
	input  logic               q_pop,
	output smct_pkg::smct_in_t q_data
);
	import smct_pkg::*;

	smct_in_t   mem_q [0:1];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ----- hdl/smct_aes.sv -----
// AES-128 encryption core, one round per cycle with the key schedule run alongside.
module smct_aes (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] din,
	input  logic [127:0] key,
	output logic         done,
	output logic [127:0] dout
);
	import smct_pkg::*;

	logic [127:0] state_q, rk_q, rk_n;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         busy_q, done_q;

	assign rk_n = key_next(rk_q, rc_q);
	assign done = done_q;
	assign dout = state_q;

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= din ^ key;
			rk_q    <= key;
			rc_q    <= RCON_FIRST;
		end else if (busy_q) begin
			state_q <= aes_round(state_q, rnd_q == AES_ROUNDS) ^ rk_n;
			rk_q    <= rk_n;
			rc_q    <= xt(rc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == AES_ROUNDS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/smct_back.sv -----
// Message sequencer: gathers bytes into blocks, chains them through AES and finishes the CMAC.
module smct_back #(
	parameter int MAX_MESSAGE_BYTES = 48,
	parameter int TI_BYTES          = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smct_pkg::smct_cfg_t cfg,
	input  logic                q_valid,
	output logic                q_pop,
	input  smct_pkg::smct_in_t  q_data,
	output logic                out_valid,
	input  logic                out_stall,
	output smct_pkg::smct_out_t out_data
);
	import smct_pkg::*;

	localparam int HDR_N = 3 + TI_BYTES;
	localparam int HW    = $clog2(HDR_N);
	localparam int LW    = $clog2(MAX_MESSAGE_BYTES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_HDR, S_BODY, S_FIN, S_WAIT, S_MK, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		P_CHAIN, P_ZERO, P_TAG
	} purpose_t;

	state_t       state_q, ret_q;
	purpose_t     purp_q;
	smct_in_t     item_q;
	logic [127:0] chain_q, buf_q, l_q;
	logic [4:0]   fill_q;
	logic [LW-1:0] len_q;
	logic         ovf_q;
	logic [HW-1:0] hdr_q;
	smct_out_t    res_q;
	logic         out_valid_q;
	smct_out_t    out_data_q;

	logic         aes_start, aes_done;
	logic [127:0] aes_din, aes_dout;
	logic [63:0]  ti_ext;
	logic [7:0]   ti_b, hdr_b, push_b;
	logic         len_full;
	logic [127:0] k1, sub_key, last_blk;
	logic [63:0]  mac;
	logic         out_free;

	smct_aes u_aes (
		.clk   (clk),
		.arst_n(arst_n),
		.start (aes_start),
		.din   (aes_din),
		.key   (cfg.key),
		.done  (aes_done),
		.dout  (aes_dout)
	);

	assign ti_ext = {32'd0, cfg.transaction_id};

	// Transaction-id bytes go out most significant first; with more than four, the leading extra bytes are zero.
	always_comb begin
		ti_b = 8'd0;
		for (int i = 0; i < TI_BYTES; i++) begin
			if (hdr_q == HW'(3 + i)) begin
				ti_b = ti_ext[8*(TI_BYTES-1-i) +: 8];
			end
		end
	end

	always_comb begin
		case (hdr_q)
			HW'(0):  hdr_b = item_q.command_code;
			HW'(1):  hdr_b = cfg.command_counter[7:0];
			HW'(2):  hdr_b = cfg.command_counter[15:8];
			default: hdr_b = ti_b;
		endcase
	end

	assign push_b   = (state_q == S_HDR) ? hdr_b : item_q.body_byte;
	assign len_full = (len_q >= LW'(MAX_MESSAGE_BYTES));

	assign k1       = gf_dbl(l_q);
	assign sub_key  = fill_q[4] ? k1 : gf_dbl(k1);
	assign last_blk = (fill_q[4] ? buf_q : set_byte(buf_q, fill_q[3:0], PAD_BYTE))
		^ sub_key ^ chain_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mac[8*(7-i) +: 8] = get_byte(aes_dout, 2*i + 1);
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	always_comb begin
		aes_start = 1'b0;
		aes_din   = chain_q ^ buf_q;
		case (state_q)
			S_HDR: begin
				aes_start = !len_full && fill_q[4];
			end
			S_BODY: begin
				aes_start = item_q.byte_present && !len_full && fill_q[4];
			end
			S_FIN: begin
				aes_start = !ovf_q;
				aes_din   = 128'd0;
			end
			S_MK: begin
				aes_start = 1'b1;
				aes_din   = last_blk;
			end
			default: begin
				aes_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_data;
		end
		if (state_q == S_WAIT && aes_done && purp_q == P_ZERO) begin
			l_q <= aes_dout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			purp_q      <= P_CHAIN;
			chain_q     <= '0;
			buf_q       <= '0;
			fill_q      <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			hdr_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// In S_DONE the output register is reloaded instead.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_data.first_item) begin
							chain_q <= '0;
							buf_q   <= '0;
							fill_q  <= '0;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							hdr_q   <= '0;
							state_q <= S_HDR;
						end else begin
							state_q <= S_BODY;
						end
					end
				end
				S_HDR, S_BODY: begin
					if (state_q == S_BODY && !item_q.byte_present) begin
						state_q <= item_q.last_item ? S_FIN : S_IDLE;
					end else if (len_full) begin
						ovf_q <= 1'b1;
						if (state_q == S_BODY) begin
							state_q <= item_q.last_item ? S_FIN : S_IDLE;
						end else if (hdr_q == HW'(HDR_N - 1)) begin
							state_q <= S_BODY;
						end else begin
							hdr_q <= hdr_q + HW'(1);
						end
					end else if (fill_q[4]) begin
						// Full block pending: chain it before the byte goes in.
						purp_q  <= P_CHAIN;
						ret_q   <= state_q;
						state_q <= S_WAIT;
					end else begin
						buf_q  <= set_byte(buf_q, fill_q[3:0], push_b);
						fill_q <= fill_q + 5'd1;
						len_q  <= len_q + LW'(1);
						if (state_q == S_BODY) begin
							state_q <= item_q.last_item ? S_FIN : S_IDLE;
						end else if (hdr_q == HW'(HDR_N - 1)) begin
							state_q <= S_BODY;
						end else begin
							hdr_q <= hdr_q + HW'(1);
						end
					end
				end
				S_FIN: begin
					if (ovf_q) begin
						res_q   <= '{mac_short: 64'd0, too_long: 1'b1};
						state_q <= S_DONE;
					end else begin
						purp_q  <= P_ZERO;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (aes_done) begin
						case (purp_q)
							P_CHAIN: begin
								chain_q <= aes_dout;
								buf_q   <= '0;
								fill_q  <= '0;
								state_q <= ret_q;
							end
							P_ZERO: begin
								state_q <= S_MK;
							end
							P_TAG: begin
								res_q   <= '{mac_short: mac, too_long: 1'b0};
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_MK: begin
					purp_q  <= P_TAG;
					state_q <= S_WAIT;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						chain_q     <= '0;
						buf_q       <= '0;
						fill_q      <= '0;
						len_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
